@@ hw/rtl/mmra_pkg.sv @@
`default_nettype none

package mmra_pkg;

    localparam int RESIDUAL_BITS = 16;

    localparam logic OP_MOTION = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    localparam logic [2:0] REPORT_LEN_BASE  = 3'd3;
    localparam logic [2:0] REPORT_LEN_WHEEL = 3'd4;

    // residual sum bounds, one bit wider than the residual
    localparam logic signed [RESIDUAL_BITS:0] SUM_HI = {2'b00, {(RESIDUAL_BITS-1){1'b1}}};
    localparam logic signed [RESIDUAL_BITS:0] SUM_LO = {2'b11, {(RESIDUAL_BITS-1){1'b0}}};
    localparam logic signed [RESIDUAL_BITS:0] SHARE_HI = (RESIDUAL_BITS+1)'(127);
    localparam logic signed [RESIDUAL_BITS:0] SHARE_LO = (RESIDUAL_BITS+1)'(-128);

    typedef struct packed {
        logic               operation;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic signed [7:0]  delta_z;
        logic [7:0]         button_bits;
        logic               wheel_wanted;
    } in_word_t;

    typedef struct packed {
        logic [7:0]        report_buttons;
        logic signed [7:0] report_x;
        logic signed [7:0] report_y;
        logic signed [7:0] report_wheel;
        logic [2:0]        report_length;
    } out_word_t;

    typedef struct packed {
        logic signed [7:0]               share;
        logic signed [RESIDUAL_BITS-1:0] residual;
    } drain_t;

endpackage

`default_nettype wire

@@ hw/rtl/mouse_motion_report_accumulator_unit.sv @@
`default_nettype none

// Channel | Signals                      | Word
// --------+------------------------------+-----------------------------------
// in      | in_valid, in_ready, in_data  | motion event or report poll
// out     | out_valid, out_ready, out_data | one report per poll
//
// One word per cycle while no poll is held back. An accepted word is held in
// the input register, then the pending/residual update and the report are done
// in a single pass into the state and output registers: a report becomes valid
// once its poll leaves the input register and the output register is written.
// Reset clears pending values, residuals and both valid flags.
// A poll waits in the input register while the output register holds an untaken
// report; motion events pass regardless.

module mouse_motion_report_accumulator_unit
    import mmra_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data
);

    localparam int RB = RESIDUAL_BITS;

    function automatic logic signed [7:0] scale_delta(input logic signed [15:0] d);
        logic signed [16:0] t;
        logic signed [15:0] h;
        logic signed [7:0]  r;
        t = $signed({d[15], d}) + $signed({16'b0, d[15]});
        if (d > 16'sd1 || d < -16'sd1)
            h = t[16:1];
        else
            h = d;
        if (h > 16'sd127)
            r = 8'sd127;
        else if (h < -16'sd128)
            r = -8'sd128;
        else
            r = h[7:0];
        return r;
    endfunction

    function automatic drain_t drain(input logic signed [RB-1:0] res,
                                     input logic signed [8:0] d);
        logic signed [RB:0] s;
        drain_t r;
        s = $signed({res[RB-1], res}) + $signed({{(RB-8){d[8]}}, d});
        if (s > SUM_HI)
            s = SUM_HI;
        if (s < SUM_LO)
            s = SUM_LO;
        if (s > SHARE_HI) begin
            r.share = 8'sd127;
            s = s - SHARE_HI;
        end
        else if (s < SHARE_LO) begin
            r.share = -8'sd128;
            s = s - SHARE_LO;
        end
        else begin
            r.share = s[7:0];
            s = '0;
        end
        r.residual = s[RB-1:0];
        return r;
    endfunction

    logic                 stage_valid_reg;
    in_word_t             stage_reg;
    logic [7:0]           pend_x_reg, pend_x_next;
    logic [7:0]           pend_y_reg, pend_y_next;
    logic [7:0]           pend_wheel_reg, pend_wheel_next;
    logic [7:0]           pend_buttons_reg, pend_buttons_next;
    logic signed [RB-1:0] res_x_reg, res_x_next;
    logic signed [RB-1:0] res_y_reg, res_y_next;
    logic                 out_valid_reg, out_valid_next;
    out_word_t            out_data_reg, out_data_next;

    logic                 is_poll;
    logic                 advance;
    logic                 replay;
    logic signed [7:0]    sx;
    logic signed [7:0]    sy;
    logic signed [8:0]    dx;
    logic signed [8:0]    dy;
    drain_t               drx;
    drain_t               dry;
    logic [7:0]           rep_x;
    logic [7:0]           rep_y;

    assign is_poll  = (stage_reg.operation == OP_POLL);
    assign advance  = stage_valid_reg && (!is_poll || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign replay   = is_poll && (pend_x_reg == 8'd0) && (pend_y_reg == 8'd0);

    always_comb
    begin
        sx = scale_delta(stage_reg.delta_x);
        sy = scale_delta(stage_reg.delta_y);
        if (is_poll) begin
            dx = '0;
            dy = '0;
        end
        else begin
            dx = {sx[7], sx};
            dy = -$signed({sy[7], sy});
        end
        drx = drain(res_x_reg, dx);
        dry = drain(res_y_reg, dy);
        rep_x = replay ? drx.share : pend_x_reg;
        rep_y = replay ? dry.share : pend_y_reg;

        pend_x_next       = pend_x_reg;
        pend_y_next       = pend_y_reg;
        pend_wheel_next   = pend_wheel_reg;
        pend_buttons_next = pend_buttons_reg;
        res_x_next        = res_x_reg;
        res_y_next        = res_y_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_data_next     = out_data_reg;

        if (advance) begin
            if (!is_poll || replay) begin
                res_x_next = drx.residual;
                res_y_next = dry.residual;
            end
            if (!is_poll) begin
                pend_x_next       = drx.share;
                pend_y_next       = dry.share;
                pend_wheel_next   = stage_reg.delta_z;
                pend_buttons_next = stage_reg.button_bits;
            end
            else begin
                pend_x_next       = '0;
                pend_y_next       = '0;
                pend_buttons_next = '0;
                out_valid_next    = 1'b1;
                out_data_next.report_buttons = pend_buttons_reg;
                out_data_next.report_x       = rep_x;
                out_data_next.report_y       = rep_y;
                if (stage_reg.wheel_wanted) begin
                    out_data_next.report_wheel  = pend_wheel_reg;
                    out_data_next.report_length = REPORT_LEN_WHEEL;
                    pend_wheel_next             = '0;
                end
                else begin
                    out_data_next.report_wheel  = '0;
                    out_data_next.report_length = REPORT_LEN_BASE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            pend_x_reg       <= '0;
            pend_y_reg       <= '0;
            pend_wheel_reg   <= '0;
            pend_buttons_reg <= '0;
            res_x_reg        <= '0;
            res_y_reg        <= '0;
        end
        else begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            out_valid_reg    <= out_valid_next;
            pend_x_reg       <= pend_x_next;
            pend_y_reg       <= pend_y_next;
            pend_wheel_reg   <= pend_wheel_next;
            pend_buttons_reg <= pend_buttons_next;
            res_x_reg        <= res_x_next;
            res_y_reg        <= res_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            stage_reg <= in_data;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ test/mmra_report_checker.sv @@
module mmra_report_checker
    import mmra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    output int        mismatches,
    output int        awaiting,
    output int        reports_seen
);

    localparam longint RES_MAX = (longint'(1) <<< (RESIDUAL_BITS - 1)) - 1;
    localparam longint RES_MIN = -RES_MAX - 1;

    typedef struct packed {
        logic [7:0]          share;
        logic signed [63:0]  rest;
    } axis_t;

    logic [7:0] pend_x;
    logic [7:0] pend_y;
    logic [7:0] pend_wheel;
    logic [7:0] pend_buttons;
    longint     resid_x;
    longint     resid_y;
    out_word_t  expected_reports[$];

    function automatic longint halve_clamp(longint d);
        if (d < -1 || d > 1)
        begin
            d = d / 2;
        end
        if (d > 127)
        begin
            d = 127;
        end
        if (d < -128)
        begin
            d = -128;
        end
        return d;
    endfunction

    function automatic axis_t settle(longint resid, longint d);
        longint s;
        axis_t  r;
        s = resid + d;
        if (s > RES_MAX)
        begin
            s = RES_MAX;
        end
        if (s < RES_MIN)
        begin
            s = RES_MIN;
        end
        if (s > 127)
        begin
            r.share = 8'd127;
            r.rest  = s - 127;
        end
        else if (s < -128)
        begin
            r.share = 8'h80;
            r.rest  = s + 128;
        end
        else
        begin
            r.share = s[7:0];
            r.rest  = 0;
        end
        return r;
    endfunction

    task automatic apply_motion(longint dx, longint dy, logic [7:0] dz, logic [7:0] btn);
        axis_t ax;
        axis_t ay;
        ax = settle(resid_x, halve_clamp(dx));
        ay = settle(resid_y, -halve_clamp(dy));
        pend_x       = ax.share;
        resid_x      = ax.rest;
        pend_y       = ay.share;
        resid_y      = ay.rest;
        pend_wheel   = dz;
        pend_buttons = btn;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            pend_x       = '0;
            pend_y       = '0;
            pend_wheel   = '0;
            pend_buttons = '0;
            resid_x      = 0;
            resid_y      = 0;
            expected_reports.delete();
            mismatches   = 0;
            reports_seen = 0;
            awaiting     <= 0;
        end
        else
        begin
            // output side first: a report can never belong to a word taken at this edge
            if (out_valid && out_ready)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    $error("report_buttons: expected no report, got %0d",
                           out_data.report_buttons);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("report_buttons", int'(want.report_buttons),
                                int'(out_data.report_buttons));
                    check_field("report_x", int'(want.report_x), int'(out_data.report_x));
                    check_field("report_y", int'(want.report_y), int'(out_data.report_y));
                    check_field("report_wheel", int'(want.report_wheel),
                                int'(out_data.report_wheel));
                    check_field("report_length", int'(want.report_length),
                                int'(out_data.report_length));
                end
            end
            if (in_valid && in_ready)
            begin
                if (in_data.operation == OP_POLL)
                begin
                    if (pend_x == 0 && pend_y == 0)
                    begin
                        apply_motion(0, 0, pend_wheel, pend_buttons);
                    end
                    want.report_buttons = pend_buttons;
                    want.report_x       = pend_x;
                    want.report_y       = pend_y;
                    pend_buttons = '0;
                    pend_x       = '0;
                    pend_y       = '0;
                    if (in_data.wheel_wanted)
                    begin
                        want.report_wheel  = pend_wheel;
                        want.report_length = REPORT_LEN_WHEEL;
                        pend_wheel         = '0;
                    end
                    else
                    begin
                        want.report_wheel  = '0;
                        want.report_length = REPORT_LEN_BASE;
                    end
                    expected_reports.push_back(want);
                end
                else
                begin
                    apply_motion(longint'(in_data.delta_x), longint'(in_data.delta_y),
                                 in_data.delta_z, in_data.button_bits);
                end
            end
            awaiting <= expected_reports.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import mmra_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int SOAK_EVENTS  = 200;
    localparam int DRAIN_POLLS  = 40;
    localparam int RANDOM_WORDS = 1590;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_word_t  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_data;

    logic hold_now  = 1'b0;
    logic hold_over = 1'b0;

    int mismatches;
    int awaiting;
    int reports_seen;
    int words_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    always #1 clk = ~clk;

    mouse_motion_report_accumulator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mmra_report_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .reports_seen (reports_seen)
    );

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] random_delta();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            return 16'($urandom_range(0, 6) - 3);
        end
        else if (pick < 5)
        begin
            return 16'($urandom_range(0, 600) - 300);
        end
        else if (pick < 9)
        begin
            return 16'($urandom);
        end
        return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.operation    = ($urandom_range(0, 9) < 3) ? OP_POLL : OP_MOTION;
        w.delta_x      = random_delta();
        w.delta_y      = random_delta();
        w.delta_z      = 8'($urandom);
        w.button_bits  = 8'($urandom);
        w.wheel_wanted = 1'($urandom);
        return w;
    endfunction

    function automatic in_word_t word_of(logic op, int dx, int dy, int dz, int btn,
                                         logic ww);
        in_word_t w;
        w.operation    = op;
        w.delta_x      = 16'(dx);
        w.delta_y      = 16'(dy);
        w.delta_z      = 8'(dz);
        w.button_bits  = 8'(btn);
        w.wheel_wanted = ww;
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        in_data  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
        begin
            @(posedge clk);
        end
    endtask

    // receiver stall pattern, plus one long hold on request
    initial
    begin
        int mode;
        int span;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_now && !hold_over)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_over <= 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            repeat (span)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= 1'b0;
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        in_word_t w;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(word_of(OP_MOTION, 32767, -32768, 127, 255, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b1));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b0));
        send_word(word_of(OP_MOTION, -32768, 32767, -128, 0, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b1));
        send_word(word_of(OP_MOTION, 1, -1, 1, 8'h01, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b1));
        send_word(word_of(OP_MOTION, -1, 1, 0, 8'h80, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b0));
        send_word(word_of(OP_MOTION, 2, -2, 5, 8'h0f, 1'b0));
        send_word(word_of(OP_MOTION, -3, 3, -5, 8'hf0, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b1));
        send_word(word_of(OP_MOTION, 255, -255, 64, 8'h55, 1'b0));
        send_word(word_of(OP_MOTION, 256, -256, -64, 8'haa, 1'b0));
        // event fields on a poll are don't-care
        send_word(word_of(OP_POLL, 16'h5a5a, 16'ha5a5, 8'h3c, 8'hc3, 1'b1));
        // wheel request on an event is don't-care
        send_word(word_of(OP_MOTION, 100, 100, 7, 8'h11, 1'b1));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b0));
        send_word(word_of(OP_POLL, -1, -1, -1, 8'hff, 1'b0));
        send_word(word_of(OP_POLL, 0, 0, 0, 0, 1'b1));
        wait_drained();

        // Y residual grows by one per full-scale upward event; polls then drain it
        for (int i = 0; i < SOAK_EVENTS; i++)
        begin
            w = random_word();
            w.operation = OP_MOTION;
            w.delta_y   = 16'(-int'($urandom_range(256, 32768)));
            send_word(w);
        end
        for (int i = 0; i < DRAIN_POLLS; i++)
        begin
            w = random_word();
            w.operation = OP_POLL;
            send_word(w);
            pace();
        end
        wait_drained();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 3)
            begin
                hold_now <= 1'b1;
                while (!hold_over)
                begin
                    send_word(random_word());
                end
            end
            send_word(random_word());
            if ($urandom_range(0, 199) == 0)
            begin
                wait_drained();
            end
            else
            begin
                pace();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("tb_top: %0d words sent, %0d reports checked", words_sent, reports_seen);
        $display("tb_top: covered field extremes, residual build-up and drain, and a long output stall");
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
